// ----- sv/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants for the wildcard glob matcher
// Buffer sizes, byte codes, operation codes, channel payloads and the
// evaluation sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

    // Buffer sizes
    localparam int unsigned MAX_PATTERN_BYTES = 256;
    localparam int unsigned MAX_SUBJECT_BYTES = 256;

    // Address and count widths (counts must hold the buffer size itself)
    localparam int unsigned PAT_AW  = $clog2(MAX_PATTERN_BYTES);
    localparam int unsigned PAT_CW  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int unsigned SUBJ_AW = $clog2(MAX_SUBJECT_BYTES);
    localparam int unsigned SUBJ_CW = $clog2(MAX_SUBJECT_BYTES + 1);

    localparam logic [PAT_CW-1:0]  PAT_FULL  = PAT_CW'(MAX_PATTERN_BYTES);
    localparam logic [SUBJ_CW-1:0] SUBJ_FULL = SUBJ_CW'(MAX_SUBJECT_BYTES);

    // Wildcard bytes
    localparam logic [7:0] STAR_BYTE  = 8'h2A;
    localparam logic [7:0] QMARK_BYTE = 8'h3F;

    // Operation codes
    localparam logic [1:0] OP_PAT  = 2'd0;
    localparam logic [1:0] OP_SUBJ = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;

    // Channel payloads
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic overflowed;
    } out_item_t;

    // Top level to sequencer
    typedef struct packed {
        logic               start;
        logic [PAT_CW-1:0]  pat_len;
        logic [SUBJ_CW-1:0] subj_len;
    } eval_cmd_t;

    // Sequencer to top level
    typedef struct packed {
        logic busy;
        logic done;
        logic matched;
    } eval_stat_t;

    // Evaluation sequencer states: each FETCH state reads both buffers,
    // the following EXEC state acts on the registered read data
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_MAIN,
        ST_EXEC_MAIN,
        ST_FETCH_STAR,
        ST_EXEC_STAR,
        ST_FETCH_SCAN,
        ST_EXEC_SCAN,
        ST_FETCH_TAIL,
        ST_EXEC_TAIL
    } eval_state_t;

endpackage

`default_nettype wire

// ----- sv/wgm_in_if.sv -----
// ----------------------------------------------------------------------------
// wgm_in_if: input channel of the glob matcher
// Valid/ready channel that carries one operation and its byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface wgm_in_if;

    logic              valid;
    logic              ready;
    wgm_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- sv/wgm_out_if.sv -----
// ----------------------------------------------------------------------------
// wgm_out_if: result channel of the glob matcher
// Valid/ready channel that carries the match and overflow flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface wgm_out_if;

    logic               valid;
    logic               ready;
    wgm_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- sv/wildcard_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: star and question-mark glob matcher
// Loads pattern and subject bytes into two buffers and, on evaluate, reports
// whether the whole subject matches the whole pattern.
// ----------------------------------------------------------------------------
// Append transactions (op 0 pattern byte, op 1 subject byte) are accepted
// back to back while no evaluation runs; a byte beyond the 256-byte buffer is
// dropped and flags overflow. An evaluate transaction (op 2) returns one
// result and empties both buffers. Evaluation walks the buffers through their
// single registered read ports; each step has a fetch state, which reads the
// pattern and subject byte, and an exec state, which compares them and moves
// the indexes. Each backtrack to the last star restarts the walk, so the worst
// case grows with pattern length times subject length. The input is not
// ready during evaluation, and an evaluate waits while a previous result has
// not been taken. Op 3 is accepted and ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_glob_matcher (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wgm_in_if.sink     req,
    wgm_out_if.source  rsp
);

    logic [wgm_pkg::PAT_CW-1:0]  pat_count_reg, pat_count_next;
    logic [wgm_pkg::SUBJ_CW-1:0] subj_count_reg, subj_count_next;
    logic                        ovf_reg, ovf_next;
    logic                        ovf_hold_reg, ovf_hold_next;
    logic                        res_valid_reg, res_valid_next;
    wgm_pkg::out_item_t          res_reg, res_next;

    logic                        accept;
    logic                        pat_we, subj_we;
    logic                        eval_go;
    wgm_pkg::eval_cmd_t          cmd;
    wgm_pkg::eval_stat_t         stat;
    logic [wgm_pkg::PAT_AW-1:0]  pat_raddr;
    logic [wgm_pkg::SUBJ_AW-1:0] subj_raddr;
    logic [7:0]                  pat_rdata, subj_rdata;

    // Accept appends while idle; hold an evaluate until the result slot is free
    assign req.ready = !stat.busy && (!res_valid_reg || (req.data.op != wgm_pkg::OP_EVAL));
    assign accept    = req.valid && req.ready;

    // Decode the accepted transaction
    always_comb
    begin
        pat_we          = 1'b0;
        subj_we         = 1'b0;
        eval_go         = 1'b0;
        pat_count_next  = pat_count_reg;
        subj_count_next = subj_count_reg;
        ovf_next        = ovf_reg;
        ovf_hold_next   = ovf_hold_reg;
        if (accept)
        begin
            unique case (req.data.op)
                wgm_pkg::OP_PAT:
                begin
                    if (pat_count_reg < wgm_pkg::PAT_FULL)
                    begin
                        pat_we         = 1'b1;
                        pat_count_next = pat_count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                wgm_pkg::OP_SUBJ:
                begin
                    if (subj_count_reg < wgm_pkg::SUBJ_FULL)
                    begin
                        subj_we         = 1'b1;
                        subj_count_next = subj_count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                wgm_pkg::OP_EVAL:
                begin
                    eval_go         = 1'b1;
                    ovf_hold_next   = ovf_reg;
                    pat_count_next  = '0;
                    subj_count_next = '0;
                    ovf_next        = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cmd.start    = eval_go;
    assign cmd.pat_len  = pat_count_reg;
    assign cmd.subj_len = subj_count_reg;

    // Result slot: load on finish, drop when taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (rsp.valid && rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (stat.done)
        begin
            res_valid_next      = 1'b1;
            res_next.matched    = stat.matched;
            res_next.overflowed = ovf_hold_reg;
        end
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.data  = res_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_count_reg  <= '0;
            subj_count_reg <= '0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            pat_count_reg  <= pat_count_next;
            subj_count_reg <= subj_count_next;
            ovf_reg        <= ovf_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ovf_hold_reg <= ovf_hold_next;
        res_reg      <= res_next;
    end

    wgm_ram #(
        .WIDTH (8),
        .DEPTH (wgm_pkg::MAX_PATTERN_BYTES)
    ) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_count_reg[wgm_pkg::PAT_AW-1:0]),
        .wdata (req.data.byte_value),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    wgm_ram #(
        .WIDTH (8),
        .DEPTH (wgm_pkg::MAX_SUBJECT_BYTES)
    ) u_subj_ram (
        .clk   (clk),
        .we    (subj_we),
        .waddr (subj_count_reg[wgm_pkg::SUBJ_AW-1:0]),
        .wdata (req.data.byte_value),
        .raddr (subj_raddr),
        .rdata (subj_rdata)
    );

    wgm_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pat_addr  (pat_raddr),
        .subj_addr (subj_raddr),
        .pat_data  (pat_rdata),
        .subj_data (subj_rdata)
    );

endmodule

`default_nettype wire

// ----- sv/wgm_ram.sv -----
// ----------------------------------------------------------------------------
// wgm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/wgm_eval.sv -----
// ----------------------------------------------------------------------------
// wgm_eval: glob evaluation sequencer
// Walks the pattern and subject buffers with one byte compare unit, keeping
// a single restore point at the most recent star.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_eval (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire wgm_pkg::eval_cmd_t          cmd,
    output wgm_pkg::eval_stat_t              stat,
    output logic [wgm_pkg::PAT_AW-1:0]       pat_addr,
    output logic [wgm_pkg::SUBJ_AW-1:0]      subj_addr,
    input  wire logic [7:0]                  pat_data,
    input  wire logic [7:0]                  subj_data
);

    wgm_pkg::eval_state_t state_reg, state_next;

    logic                         have_reg, have_next;
    logic [wgm_pkg::PAT_CW-1:0]   pe_reg, pe_next;
    logic [wgm_pkg::SUBJ_CW-1:0]  se_reg, se_next;
    logic [wgm_pkg::PAT_CW-1:0]   pi_reg, pi_next;
    logic [wgm_pkg::SUBJ_CW-1:0]  si_reg, si_next;
    logic [wgm_pkg::PAT_CW-1:0]   rp_reg, rp_next;
    logic [wgm_pkg::SUBJ_CW-1:0]  rs_reg, rs_next;

    logic                         p_live, s_live;
    logic                         is_star, is_qmark, bytes_eq;
    logic [wgm_pkg::PAT_CW-1:0]   pi_inc;
    logic [wgm_pkg::SUBJ_CW-1:0]  si_inc;
    logic [wgm_pkg::SUBJ_CW-1:0]  rs_inc;
    logic                         main_star, main_adv, main_hit, main_cont, main_miss;
    logic                         scan_step, tail_step;
    logic                         finish, verdict;

    // Shared compare unit and step decisions
    always_comb
    begin
        p_live    = pi_reg < pe_reg;
        s_live    = si_reg < se_reg;
        is_star   = pat_data == wgm_pkg::STAR_BYTE;
        is_qmark  = pat_data == wgm_pkg::QMARK_BYTE;
        bytes_eq  = pat_data == subj_data;
        pi_inc    = pi_reg + 1'b1;
        si_inc    = si_reg + 1'b1;
        rs_inc    = rs_reg + 1'b1;
        main_star = s_live && p_live && is_star;
        main_adv  = s_live && p_live && !is_star && (bytes_eq || is_qmark);
        main_hit  = main_adv && (pi_inc == pe_reg) && (si_inc == se_reg);
        main_cont = main_adv && (pi_inc != pe_reg);
        main_miss = s_live && !main_star && !main_cont && !main_hit;
        scan_step = s_live && !bytes_eq;
        tail_step = p_live && is_star;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wgm_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = wgm_pkg::ST_FETCH_MAIN;
                end
            end
            wgm_pkg::ST_FETCH_MAIN: state_next = wgm_pkg::ST_EXEC_MAIN;
            wgm_pkg::ST_EXEC_MAIN:
            begin
                if (!s_live)
                begin
                    state_next = wgm_pkg::ST_FETCH_TAIL;
                end
                else if (main_star)
                begin
                    state_next = wgm_pkg::ST_FETCH_STAR;
                end
                else if (main_hit || (main_miss && !have_reg))
                begin
                    state_next = wgm_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = wgm_pkg::ST_FETCH_MAIN;
                end
            end
            wgm_pkg::ST_FETCH_STAR: state_next = wgm_pkg::ST_EXEC_STAR;
            wgm_pkg::ST_EXEC_STAR:
            begin
                if (!p_live)
                begin
                    state_next = wgm_pkg::ST_IDLE;
                end
                else if (is_star)
                begin
                    state_next = wgm_pkg::ST_FETCH_STAR;
                end
                else if (is_qmark)
                begin
                    state_next = wgm_pkg::ST_FETCH_MAIN;
                end
                else
                begin
                    state_next = wgm_pkg::ST_FETCH_SCAN;
                end
            end
            wgm_pkg::ST_FETCH_SCAN: state_next = wgm_pkg::ST_EXEC_SCAN;
            wgm_pkg::ST_EXEC_SCAN:
            begin
                if (scan_step)
                begin
                    state_next = wgm_pkg::ST_FETCH_SCAN;
                end
                else
                begin
                    state_next = wgm_pkg::ST_FETCH_MAIN;
                end
            end
            wgm_pkg::ST_FETCH_TAIL: state_next = wgm_pkg::ST_EXEC_TAIL;
            wgm_pkg::ST_EXEC_TAIL:
            begin
                if (tail_step)
                begin
                    state_next = wgm_pkg::ST_FETCH_TAIL;
                end
                else
                begin
                    state_next = wgm_pkg::ST_IDLE;
                end
            end
            default: state_next = wgm_pkg::ST_IDLE;
        endcase
    end

    // Index updates, restore point and result
    always_comb
    begin
        have_next = have_reg;
        pe_next   = pe_reg;
        se_next   = se_reg;
        pi_next   = pi_reg;
        si_next   = si_reg;
        rp_next   = rp_reg;
        rs_next   = rs_reg;
        finish    = 1'b0;
        verdict   = 1'b0;
        unique case (state_reg)
            wgm_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    pe_next   = cmd.pat_len;
                    se_next   = cmd.subj_len;
                    pi_next   = '0;
                    si_next   = '0;
                    rp_next   = '0;
                    rs_next   = '0;
                    have_next = 1'b0;
                end
            end
            wgm_pkg::ST_EXEC_MAIN:
            begin
                if (main_star)
                begin
                    pi_next = pi_inc;
                end
                else if (main_hit)
                begin
                    finish  = 1'b1;
                    verdict = 1'b1;
                end
                else if (main_cont)
                begin
                    pi_next = pi_inc;
                    si_next = si_inc;
                end
                else if (main_miss)
                begin
                    // Fall back to the restore point one subject byte further on
                    if (have_reg)
                    begin
                        pi_next = rp_reg;
                        rs_next = rs_inc;
                        si_next = rs_inc;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            wgm_pkg::ST_EXEC_STAR:
            begin
                if (!p_live)
                begin
                    // Trailing star swallows the rest of the subject
                    finish  = 1'b1;
                    verdict = 1'b1;
                end
                else if (is_star)
                begin
                    pi_next = pi_inc;
                end
                else if (is_qmark)
                begin
                    have_next = 1'b1;
                    rp_next   = pi_reg;
                    rs_next   = si_reg;
                end
            end
            wgm_pkg::ST_EXEC_SCAN:
            begin
                // Skip ahead to the next copy of the literal after the star
                if (scan_step)
                begin
                    si_next = si_inc;
                end
                else
                begin
                    have_next = 1'b1;
                    rp_next   = pi_reg;
                    rs_next   = si_reg;
                end
            end
            wgm_pkg::ST_EXEC_TAIL:
            begin
                if (tail_step)
                begin
                    pi_next = pi_inc;
                end
                else
                begin
                    finish  = 1'b1;
                    verdict = !p_live;
                end
            end
            wgm_pkg::ST_FETCH_MAIN,
            wgm_pkg::ST_FETCH_STAR,
            wgm_pkg::ST_FETCH_SCAN,
            wgm_pkg::ST_FETCH_TAIL:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wgm_pkg::ST_IDLE;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg  <= have_next;
        end
    end

    // Index registers
    always_ff @(posedge clk)
    begin
        pe_reg <= pe_next;
        se_reg <= se_next;
        pi_reg <= pi_next;
        si_reg <= si_next;
        rp_reg <= rp_next;
        rs_reg <= rs_next;
    end

    // Buffer read addresses and status
    assign pat_addr     = pi_reg[wgm_pkg::PAT_AW-1:0];
    assign subj_addr    = si_reg[wgm_pkg::SUBJ_AW-1:0];
    assign stat.busy    = state_reg != wgm_pkg::ST_IDLE;
    assign stat.done    = finish;
    assign stat.matched = verdict;

endmodule

`default_nettype wire

// ----- sv/wgm_chk.sv -----
// ----------------------------------------------------------------------------
// wgm_chk: port-level checks for the glob matcher
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic [1:0] req_op,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] rsp_data
);

    logic eval_taken;

    assign eval_taken = req_valid && req_ready && (req_op == wgm_pkg::OP_EVAL);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its flags
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("result changed while stalled");

    // An evaluate is taken only with the result slot empty
    a_eval_slot: assert property (@(posedge clk) disable iff (!rst_n)
        eval_taken |-> !rsp_valid)
        else $error("evaluate taken while a result waits");

    // An evaluate makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eval_taken |=> !req_ready)
        else $error("input ready right after an evaluate");

    // A new result only ever follows a busy cycle
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without an evaluation");

endmodule

bind wildcard_glob_matcher wgm_chk u_wgm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_op    (req.data.op),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
